### hw/rtl/clipped_sprite_blitter_defines.svh
// Assertion helpers shared by the blitter RTL.
`ifndef CLIPPED_SPRITE_BLITTER_DEFINES_SVH
`define CLIPPED_SPRITE_BLITTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/csb_pkg.sv
package csb_pkg;

	localparam int MAX_DIM  = 2048;
	localparam int DIM_W    = $clog2(MAX_DIM) + 1;
	localparam int COORD_W  = 11;
	localparam int DRAW_W   = 13;
	localparam int PCT_W    = 7;
	localparam int PIX_W    = 32;
	localparam int KEY_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	// sprite_width * percent, saturated percent keeps this below 2^(DIM_W+PCT_W)
	localparam int AREA_W   = DIM_W + PCT_W;

	localparam logic [PIX_W-1:0] KEY_MASK = 32'h00ff_ffff;
	localparam logic [PIX_W-1:0] LOW_HALF = 32'h0000_7f7f;
	localparam logic [PIX_W-1:0] RED_MASK = 32'h00ff_0000;
	localparam logic [PIX_W-1:0] ALL_HALF = 32'h007f_7f7f;
	localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOR_KEY     = 3'd0,
		REG_DRAW_STYLE    = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_ANCHOR_X      = 3'd4,
		REG_ANCHOR_Y      = 3'd5,
		REG_DEST_WIDTH    = 3'd6,
		REG_DEST_HEIGHT   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		STYLE_COPY = 2'd0,
		STYLE_KEY  = 2'd1,
		STYLE_RED  = 2'd2,
		STYLE_HALF = 2'd3
	} style_t;

	typedef struct packed {
		logic [KEY_W-1:0]   color_key;
		style_t             draw_style;
		logic [DIM_W-1:0]   sprite_width;
		logic [DIM_W-1:0]   sprite_height;
		logic [COORD_W-1:0] anchor_x;
		logic [COORD_W-1:0] anchor_y;
		logic [DIM_W-1:0]   dest_width;
		logic [DIM_W-1:0]   dest_height;
	} cfg_t;

	typedef struct packed {
		logic               in_rect;
		logic               last;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pos_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

### hw/rtl/csb_cfg.sv
module csb_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output csb_pkg::cfg_t                   cfg
);

	csb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_key     <= '0;
			cfg_q.draw_style    <= csb_pkg::STYLE_KEY;
			cfg_q.sprite_width  <= csb_pkg::DIM_W'(1);
			cfg_q.sprite_height <= csb_pkg::DIM_W'(1);
			cfg_q.anchor_x      <= '0;
			cfg_q.anchor_y      <= '0;
			cfg_q.dest_width    <= csb_pkg::DIM_W'(640);
			cfg_q.dest_height   <= csb_pkg::DIM_W'(480);
		end else if (cfg_valid) begin
			unique case (csb_pkg::reg_idx_t'(cfg_index))
				csb_pkg::REG_COLOR_KEY: begin
					cfg_q.color_key <= cfg_data[csb_pkg::KEY_W-1:0];
				end
				csb_pkg::REG_DRAW_STYLE: begin
					cfg_q.draw_style <= csb_pkg::style_t'(cfg_data[1:0]);
				end
				csb_pkg::REG_SPRITE_WIDTH: begin
					cfg_q.sprite_width <= cfg_data[csb_pkg::DIM_W-1:0];
				end
				csb_pkg::REG_SPRITE_HEIGHT: begin
					cfg_q.sprite_height <= cfg_data[csb_pkg::DIM_W-1:0];
				end
				csb_pkg::REG_ANCHOR_X: begin
					cfg_q.anchor_x <= cfg_data[csb_pkg::COORD_W-1:0];
				end
				csb_pkg::REG_ANCHOR_Y: begin
					cfg_q.anchor_y <= cfg_data[csb_pkg::COORD_W-1:0];
				end
				csb_pkg::REG_DEST_WIDTH: begin
					cfg_q.dest_width <= cfg_data[csb_pkg::DIM_W-1:0];
				end
				csb_pkg::REG_DEST_HEIGHT: begin
					cfg_q.dest_height <= cfg_data[csb_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hw/rtl/csb_shade.sv
module csb_shade (
	input  csb_pkg::cfg_t                cfg,
	input  logic [csb_pkg::PIX_W-1:0]    pixel,
	output logic                         keyed,
	output logic [csb_pkg::PIX_W-1:0]    shaded
);

	logic key_hit;

	assign key_hit = (pixel & csb_pkg::KEY_MASK) == {8'h00, cfg.color_key};

	always_comb begin
		keyed  = key_hit;
		shaded = pixel;
		unique case (cfg.draw_style)
			csb_pkg::STYLE_COPY: begin
				keyed  = 1'b0;
				shaded = pixel;
			end
			csb_pkg::STYLE_KEY: begin
				shaded = pixel;
			end
			csb_pkg::STYLE_RED: begin
				shaded = ((pixel >> 1) & csb_pkg::LOW_HALF) | (pixel & csb_pkg::RED_MASK);
			end
			csb_pkg::STYLE_HALF: begin
				shaded = (pixel >> 1) & csb_pkg::ALL_HALF;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/csb_walk.sv
module csb_walk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  csb_pkg::cfg_t                   cfg,
	input  logic                            advance,
	input  logic                            first,
	input  logic [csb_pkg::DRAW_W-1:0]      draw_x,
	input  logic [csb_pkg::DRAW_W-1:0]      draw_y,
	input  logic [csb_pkg::PCT_W-1:0]       width_percent,
	output csb_pkg::pos_t                   pos
);

	localparam int DW  = csb_pkg::DRAW_W;
	localparam int DMW = csb_pkg::DIM_W;
	localparam int AW  = csb_pkg::AREA_W;

	// state: origin, visible area (width * percent, compared against 100 * (col+1))
	logic [DW-1:0]  origin_x_q, origin_y_q;
	logic [AW-1:0]  area_q;
	logic [DMW-1:0] col_q, row_q;

	logic [DMW-1:0] sw, sh, dw, dh;
	logic [csb_pkg::PCT_W-1:0] pct;
	logic [DW:0]    diff_x, diff_y;
	logic [DW-1:0]  ox, oy, new_ox, new_oy;
	logic [AW-1:0]  area, new_area;
	logic [DMW-1:0] col, row, col_inc, row_inc;
	logic [DW:0]    dx, dy;
	logic [AW-1:0]  col_lim;
	logic           active, vis, in_x, in_y;

	assign sw = csb_pkg::clamp_dim(cfg.sprite_width);
	assign sh = csb_pkg::clamp_dim(cfg.sprite_height);
	assign dw = csb_pkg::clamp_dim(cfg.dest_width);
	assign dh = csb_pkg::clamp_dim(cfg.dest_height);

	assign pct = (width_percent > csb_pkg::FULL_PCT) ? csb_pkg::FULL_PCT : width_percent;

	// draw minus anchor; only the low side can run past -4096
	assign diff_x = {draw_x[DW-1], draw_x} - {{(DW+1-csb_pkg::COORD_W){1'b0}}, cfg.anchor_x};
	assign diff_y = {draw_y[DW-1], draw_y} - {{(DW+1-csb_pkg::COORD_W){1'b0}}, cfg.anchor_y};
	assign new_ox = (diff_x[DW] && !diff_x[DW-1]) ? {1'b1, {(DW-1){1'b0}}} : diff_x[DW-1:0];
	assign new_oy = (diff_y[DW] && !diff_y[DW-1]) ? {1'b1, {(DW-1){1'b0}}} : diff_y[DW-1:0];
	assign new_area = {{(AW-DMW){1'b0}}, sw} * {{(AW-csb_pkg::PCT_W){1'b0}}, pct};

	assign ox   = first ? new_ox   : origin_x_q;
	assign oy   = first ? new_oy   : origin_y_q;
	assign area = first ? new_area : area_q;
	assign col  = first ? '0 : col_q;
	assign row  = first ? '0 : row_q;

	assign col_inc = col + DMW'(1);
	assign row_inc = row + DMW'(1);

	assign active = (row < sh) && (col < sw);

	// col < area/100  <=>  100*(col+1) <= area
	assign col_lim = ({{(AW-DMW){1'b0}}, col_inc} << 6) + ({{(AW-DMW){1'b0}}, col_inc} << 5)
		+ ({{(AW-DMW){1'b0}}, col_inc} << 2);
	assign vis = col_lim <= area;

	assign dx = {ox[DW-1], ox} + {{(DW+1-DMW){1'b0}}, col};
	assign dy = {oy[DW-1], oy} + {{(DW+1-DMW){1'b0}}, row};
	assign in_x = !dx[DW] && (dx[DW-1:0] < {{(DW-DMW){1'b0}}, dw});
	assign in_y = !dy[DW] && (dy[DW-1:0] < {{(DW-DMW){1'b0}}, dh});

	assign pos.in_rect = active && vis && in_x && in_y;
	assign pos.last    = active && (col_inc == sw) && (row_inc == sh);
	assign pos.x       = dx[csb_pkg::COORD_W-1:0];
	assign pos.y       = dy[csb_pkg::COORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			area_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (advance) begin
			if (first) begin
				origin_x_q <= new_ox;
				origin_y_q <= new_oy;
				area_q     <= new_area;
				col_q      <= '0;
				row_q      <= '0;
			end
			if (active) begin
				if (col_inc >= sw) begin
					row_q <= row_inc;
					col_q <= (row_inc >= sh) ? sw : '0;
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

endmodule

### hw/rtl/clipped_sprite_blitter.sv
// Clipped sprite blitter. Sprite pixels stream in raster order, one word per
// clock while in_stall is low; every accepted pixel yields exactly one result
// word, in order; it passes the input register, is presented on the outputs
// from the result register, taken when not stalled. A word with first
// set latches origin = draw position - anchor (saturated at -4096) and the
// visible width sprite_width * min(width_percent, 100) / 100, and restarts the
// column/row walk. A pixel is written (write_enable) when it lies inside the
// destination rectangle, its column is below the visible width and it is not
// the color key (styles 1-3). Styles: 0 copy, 1 color key, 2 halve green and
// blue keeping red, 3 halve all colors. Unwritten results carry zero
// coordinates and pixel; last marks the final sprite pixel, and pixels past
// the sprite end are not written until the next first. Sizes are clamped to
// 1..2048. Sustained rate is one pixel per clock when out_stall is low, set
// by the column/row counter update in the compute stage. The input register
// and the output register each hold one word, so in_stall rises only when
// both are full and out_stall is high. Configuration writes are taken every
// cycle (cfg_ready is tied high) and must only happen while the pipe is empty.
`include "clipped_sprite_blitter_defines.svh"

module clipped_sprite_blitter (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [csb_pkg::PIX_W-1:0]       pixel,
	input  logic                            first,
	input  logic signed [csb_pkg::DRAW_W-1:0] draw_x,
	input  logic signed [csb_pkg::DRAW_W-1:0] draw_y,
	input  logic [csb_pkg::PCT_W-1:0]       width_percent,
	// result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            write_enable,
	output logic [csb_pkg::COORD_W-1:0]     dest_x,
	output logic [csb_pkg::COORD_W-1:0]     dest_y,
	output logic [csb_pkg::PIX_W-1:0]       out_pixel,
	output logic                            last
);

	csb_pkg::cfg_t cfg;
	csb_pkg::pos_t pos;

	// input register
	logic                           valid_s1;
	logic [csb_pkg::PIX_W-1:0]      pixel_s1;
	logic                           first_s1;
	logic [csb_pkg::DRAW_W-1:0]     draw_x_s1, draw_y_s1;
	logic [csb_pkg::PCT_W-1:0]      pct_s1;

	// result register
	logic                           valid_s2;
	logic                           we_s2;
	logic [csb_pkg::COORD_W-1:0]    x_s2, y_s2;
	logic [csb_pkg::PIX_W-1:0]      pix_s2;
	logic                           last_s2;

	logic                           advance, load_s1, keyed, we;
	logic [csb_pkg::PIX_W-1:0]      shaded;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	csb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csb_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.advance       (advance),
		.first         (first_s1),
		.draw_x        (draw_x_s1),
		.draw_y        (draw_y_s1),
		.width_percent (pct_s1),
		.pos           (pos)
	);

	csb_shade u_shade (
		.cfg    (cfg),
		.pixel  (pixel_s1),
		.keyed  (keyed),
		.shaded (shaded)
	);

	assign we = pos.in_rect && !keyed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			pixel_s1  <= pixel;
			first_s1  <= first;
			draw_x_s1 <= draw_x;
			draw_y_s1 <= draw_y;
			pct_s1    <= width_percent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// unwritten pixels report zero position and data
	always_ff @(posedge clk) begin
		if (advance) begin
			we_s2   <= we;
			x_s2    <= we ? pos.x : '0;
			y_s2    <= we ? pos.y : '0;
			pix_s2  <= we ? shaded : '0;
			last_s2 <= pos.last;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign dest_x       = x_s2;
	assign dest_y       = y_s2;
	assign out_pixel    = pix_s2;
	assign last         = last_s2;

	`CSB_ASSERT_IMP(a_stall_only_when_full, in_stall, valid_s1 && valid_s2 && out_stall, "input stalled while pipe has room")
	`CSB_ASSERT_NXT(a_s1_drains, valid_s1 && !out_stall, out_valid, "stage 1 word did not reach output")
	`CSB_ASSERT_IMP(a_nowrite_zero, out_valid && !write_enable, dest_x == '0 && dest_y == '0 && out_pixel == '0, "unwritten result not zeroed")

endmodule
